### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define AST_IMP(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is high.
`define AST_NXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define AST_NXT_ALL(lbl, ck, a, b) \
  lbl: assert property (@(posedge ck) (a) |=> (b)) \
    else $error("assertion failed");

`endif

### design/rmtf_pkg.sv
package rmtf_pkg;

  localparam int FIFO_DEPTH    = 8;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int RATE_W        = 10;
  localparam int CREDIT_W      = 11;
  localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W         = $clog2(FIFO_DEPTH);

  // Stream widths: payload in, payload plus three status bits out, whole bytes
  localparam int S_TDATA_W = ((PAYLOAD_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W = ((PAYLOAD_WIDTH + 3 + 7) / 8) * 8;

  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RECV_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_XMIT_RATE = 1'd1;

  localparam logic [RATE_W-1:0]   RATE_RESET   = 10'd1;
  localparam logic [CREDIT_W-1:0] CREDIT_RESET = 11'd1;

  // Queue status toward the top level for the request being processed
  typedef struct packed {
    logic                     head_valid;
    logic [PAYLOAD_WIDTH-1:0] head_data;
    logic                     full;
  } queue_status_t;

endpackage

### design/rmtf_queue.sv
module rmtf_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic                              push,
  input  logic [rmtf_pkg::PAYLOAD_WIDTH-1:0] push_data,
  input  logic                              pop,
  output rmtf_pkg::queue_status_t           status
);
  import rmtf_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(FIFO_DEPTH - 1);

  logic [PAYLOAD_WIDTH-1:0] mem [FIFO_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] head_q;
  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         rd_ptr;
  logic [PTR_W-1:0]         rd_ptr_next;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_pushed;
  logic [CNT_W-1:0]         count_next;
  logic                     push_ok;
  logic                     pop_ok;

  // Drop a push while full; a push into an empty queue falls through
  always_comb begin
    push_ok      = push && (count != DEPTH_CNT);
    count_pushed = count + CNT_W'(push_ok);
    pop_ok       = pop && (count_pushed != '0);
    count_next   = count_pushed - CNT_W'(pop_ok);
    rd_ptr_next  = rd_ptr;
    if (pop_ok) begin
      rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
    end
    status.head_valid = (count_pushed != '0);
    if (count == '0) begin
      status.head_data = push_ok ? push_data : '0;
    end else begin
      status.head_data = head_q;
    end
    status.full = (count_next == DEPTH_CNT);
  end

  // Write at the tail and fetch the next head, bypassing a write to that entry
  always_ff @(posedge clk) begin
    if (step) begin
      if (push_ok) begin
        mem[wr_ptr] <= push_data;
      end
      head_q <= (push_ok && (wr_ptr == rd_ptr_next)) ? push_data : mem[rd_ptr_next];
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else if (step) begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

### design/rmtf_rate.sv
module rmtf_rate (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [rmtf_pkg::RATE_W-1:0]  recv_rate,
  input  logic [rmtf_pkg::RATE_W-1:0]  xmit_rate,
  output logic                         sent
);
  import rmtf_pkg::*;

  logic [CREDIT_W-1:0] credit;
  logic [CREDIT_W-1:0] credit_next;
  logic [RATE_W-1:0]   diff;
  logic                rate_ok;

  // Send every step when the receiver is no faster, else spend credit while it exceeds the rate gap, or earn credit
  always_comb begin
    rate_ok     = (recv_rate <= xmit_rate);
    diff        = recv_rate - xmit_rate;
    credit_next = credit;
    if (rate_ok) begin
      sent = 1'b1;
    end else if (credit > {1'b0, diff}) begin
      sent        = 1'b1;
      credit_next = credit - {1'b0, diff};
    end else begin
      sent        = 1'b0;
      credit_next = credit + {1'b0, xmit_rate};
    end
  end

  // Hold credit between steps
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= CREDIT_RESET;
    end else if (step) begin
      credit <= credit_next;
    end
  end

endmodule

### design/rate_matched_tx_fifo_core.sv
// Transmit FIFO with a credit rate matcher. Each request on the slave stream is
// one link tick: s_tuser says whether it carries a packet (s_tdata) to queue,
// and each tick gives exactly one result on the master stream with the packet
// sent (or held), the send flag, the strobe level and the full flag. One
// request is taken every clock cycle unless master backpressure stalls it; a
// request passes the input register and then the result register; the credit
// update and queue push and pop happen between them. Backpressure on the master
// side stalls the slave side once both registers hold work. The user writes
// rates on the cfg port while the stream is idle; the block does not enforce it.
module rate_matched_tx_fifo_core (
  input  logic                               clk,
  input  logic                               rst,
  // slave stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rmtf_pkg::S_TDATA_W-1:0]     s_tdata,   // push_payload
  input  logic                               s_tuser,   // push_valid
  // master stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rmtf_pkg::M_TDATA_W-1:0]     m_tdata,   // send_payload, sent_now,
                                                        // strobe_level, is_full
  output logic                               m_tuser,   // send_valid
  // configuration
  input  logic                               cfg_we,
  input  logic [rmtf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmtf_pkg::RATE_W-1:0]        cfg_wdata
);
  import rmtf_pkg::*;

  logic [RATE_W-1:0]        recv_rate;
  logic [RATE_W-1:0]        xmit_rate;

  logic                     in_valid;
  logic                     in_push;
  logic [PAYLOAD_WIDTH-1:0] in_payload;

  logic                     out_valid;
  logic                     last_valid;
  logic [PAYLOAD_WIDTH-1:0] last_payload;
  logic                     sent_now;
  logic                     strobe;
  logic                     full;

  logic                     advance;
  logic                     sent;
  queue_status_t            qstat;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      recv_rate <= RATE_RESET;
      xmit_rate <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RECV_RATE: recv_rate <= cfg_wdata;
        REG_XMIT_RATE: xmit_rate <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Process the held request when the result register is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_push    <= s_tuser;
      in_payload <= s_tdata[PAYLOAD_WIDTH-1:0];
    end
  end

  rmtf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .push      (in_push),
    .push_data (in_payload),
    .pop       (sent),
    .status    (qstat)
  );

  rmtf_rate u_rate (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .recv_rate (recv_rate),
    .xmit_rate (xmit_rate),
    .sent      (sent)
  );

  // Result register: hold the last packet sent, toggle strobe on each send
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      last_valid   <= 1'b0;
      last_payload <= '0;
      sent_now     <= 1'b0;
      strobe       <= 1'b0;
      full         <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        sent_now  <= sent;
        full      <= qstat.full;
        if (sent) begin
          last_valid   <= qstat.head_valid;
          last_payload <= qstat.head_valid ? qstat.head_data : '0;
          strobe       <= !strobe;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pack the result
  always_comb begin
    m_tdata                    = '0;
    m_tdata[PAYLOAD_WIDTH-1:0] = last_payload;
    m_tdata[PAYLOAD_WIDTH]     = sent_now;
    m_tdata[PAYLOAD_WIDTH+1]   = strobe;
    m_tdata[PAYLOAD_WIDTH+2]   = full;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = last_valid;

endmodule

### design/rmtf_checker.sv
`include "assert_macros.svh"

module rmtf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rmtf_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tuser
);
  import rmtf_pkg::*;

  // No result right after reset
  `AST_NXT_ALL(a_reset_empty, clk, rst, !m_tvalid)

  // A stalled result holds
  `AST_NXT(a_stall_hold, clk, rst, m_tvalid && !m_tready,
           m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // An empty packet carries a zero payload
  `AST_IMP(a_empty_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[PAYLOAD_WIDTH-1:0] == '0)

  // An empty result register never blocks the input side
  `AST_IMP(a_ready_free, clk, rst, !m_tvalid, s_tready)

endmodule

bind rate_matched_tx_fifo_core rmtf_checker u_rmtf_checker (.*);
